>>> rtl/core/tmon_pkg.sv
// Shared constants and types for the three-channel thermal monitor.
package tmon_pkg;

  localparam int          NUM_CH         = 3;
  localparam int          WINDOW_LEN_DEF = 8;
  localparam int          SAMPLE_W       = 8;
  localparam int          CH_W           = 2;
  localparam int          OUT_TDATA_W    = 24;

  localparam logic [CH_W-1:0] CH_FIRST = 2'd0;
  localparam logic [CH_W-1:0] CH_LAST  = 2'd2;

  localparam logic [7:0]  CRIT_RST = 8'd43;
  localparam logic [7:0]  HIGH_RST = 8'd62;
  localparam logic [7:0]  HOT_RST  = 8'hFF;

  // APB register map
  localparam int          PADDR_W        = 3;
  localparam logic [PADDR_W-1:0] ADDR_CRIT = 3'h0;
  localparam logic [PADDR_W-1:0] ADDR_HIGH = 3'h4;

  typedef enum logic [1:0] {
    ALARM_NORMAL = 2'd0,
    ALARM_HIGH   = 2'd1,
    ALARM_CRIT   = 2'd2
  } alarm_e;

endpackage

>>> rtl/core/three_channel_thermal_monitor.sv
// Three-channel thermal monitor: per-channel moving average, hottest tracking, alarm.
//
// Path from an accepted input transaction to its result on m_axis: window memory
//   read, then sum/average/alarm into the output register.
// Throughput: one transaction per cycle unless m_axis back-pressure stalls; the window
//   memory takes one read and one write per cycle, and the running sums avoid re-adding the window.
// Reset: rst_ni clears control state, sums, positions and the entry valid bits
//   at once; hottest resets to 255, levels to 43/62. No clearing pass.
module three_channel_thermal_monitor #(
  parameter int WINDOW_LEN = tmon_pkg::WINDOW_LEN_DEF  // 2..64 samples per channel
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream, tdata: [7:0] sample
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,
  // result stream, tdata: [1:0] sampled_channel, [9:2] averaged_reading,
  // [17:10] hottest_reading, [19:18] alarm_level, [21:20] next_channel, [23:22] zero
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tmon_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tmon_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tmon_pkg::*;

  // Window memory holds NUM_CH rows of WINDOW_LEN samples.
  localparam int DEPTH   = NUM_CH * WINDOW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = $clog2(WINDOW_LEN);
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN);
  // Exact divide by WINDOW_LEN: multiply by ceil(2^DIV_SH / WINDOW_LEN), shift.
  localparam int DIV_SH  = SUM_W + $clog2(WINDOW_LEN);
  localparam int DIV_MUL = ((1 << DIV_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int PROD_W  = SUM_W + DIV_SH + 1;

  // ---------------- configuration registers ----------------
  logic [7:0] crit_q, high_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q <= CRIT_RST;
      high_q <= HIGH_RST;
    end else if (cfg_wr) begin
      if (paddr == ADDR_CRIT) crit_q <= pwdata[7:0];
      if (paddr == ADDR_HIGH) high_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CRIT) prdata = {24'd0, crit_q};
    if (paddr == ADDR_HIGH) prdata = {24'd0, high_q};
  end

  // ---------------- handshake ----------------
  logic s1_valid_q;
  logic s1_adv;
  logic in_acc;
  logic out_valid_q;

  assign s1_adv        = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s1_adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // ---------------- stage 0: slot select, memory read-before-write ----------------
  logic [CH_W-1:0] ch_q;
  logic [PW-1:0]   pos_q [NUM_CH];
  logic [AW-1:0]   slot;
  logic [7:0]      mem [DEPTH];
  logic [7:0]      old_rd_q;
  logic [DEPTH-1:0] ent_vld_q;
  logic            old_vld_q;
  logic [CH_W-1:0] s1_ch_q;
  logic [7:0]      s1_smp_q;

  assign slot = AW'(ch_q) * AW'(WINDOW_LEN) + AW'(pos_q[ch_q]);

  // The read returns the entry's old contents; the write lands in the same edge.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      old_rd_q  <= mem[slot];
      mem[slot] <= s_axis_tdata;
      s1_smp_q  <= s_axis_tdata;
      s1_ch_q   <= ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q       <= CH_FIRST;
      ent_vld_q  <= '0;
      old_vld_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) pos_q[i] <= '0;
    end else begin
      if (in_acc) begin
        old_vld_q       <= ent_vld_q[slot];
        ent_vld_q[slot] <= 1'b1;
        ch_q            <= (ch_q == CH_LAST) ? CH_FIRST : ch_q + 2'd1;
        pos_q[ch_q]     <= (pos_q[ch_q] == PW'(WINDOW_LEN - 1)) ? '0 : pos_q[ch_q] + PW'(1);
      end
      if (in_acc)      s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
    end
  end

  // ---------------- stage 1: running sum, average, hottest, alarm ----------------
  // Same-channel items are three transactions apart and commit in order,
  // so the sum read here is always up to date.
  logic [SUM_W-1:0]  sum_q [NUM_CH];
  logic [SUM_W-1:0]  sum_new;
  logic [7:0]        old_smp;
  logic [PROD_W-1:0] prod;
  logic [7:0]        avg;
  logic [7:0]        hot_q, hot_new;
  alarm_e            alarm;
  logic [CH_W-1:0]   next_ch;
  logic [OUT_TDATA_W-1:0] out_data_q;

  assign old_smp = old_vld_q ? old_rd_q : 8'd0;
  assign sum_new = sum_q[s1_ch_q] - SUM_W'(old_smp) + SUM_W'(s1_smp_q);
  assign prod    = PROD_W'(sum_new) * PROD_W'(DIV_MUL);
  assign avg     = prod[DIV_SH +: 8];

  // Channel 2 closes the round and restarts the minimum.
  assign hot_new = (s1_ch_q == CH_LAST) ? avg : ((avg < hot_q) ? avg : hot_q);
  assign next_ch = (s1_ch_q == CH_LAST) ? CH_FIRST : s1_ch_q + 2'd1;

  always_comb begin
    priority if (hot_new < crit_q) alarm = ALARM_CRIT;
    else if (hot_new < high_q)     alarm = ALARM_HIGH;
    else                           alarm = ALARM_NORMAL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_q       <= HOT_RST;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) sum_q[i] <= '0;
    end else begin
      if (s1_adv) begin
        sum_q[s1_ch_q] <= sum_new;
        hot_q          <= hot_new;
      end
      if (s1_adv)             out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_data_q <= {2'b00, next_ch, alarm, hot_new, avg, s1_ch_q};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/core/tmon_checker.sv
// Port-level assertions for the thermal monitor, bound to the top level.
module tmon_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tmon_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import tmon_pkg::*;

  logic [CH_W-1:0] o_ch, o_next;
  logic [7:0]      o_avg, o_hot;
  logic [1:0]      o_alarm;

  assign o_ch    = m_axis_tdata[1:0];
  assign o_avg   = m_axis_tdata[9:2];
  assign o_hot   = m_axis_tdata[17:10];
  assign o_alarm = m_axis_tdata[19:18];
  assign o_next  = m_axis_tdata[21:20];

  // round-robin channel follow-on
  a_next_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((o_ch == CH_LAST && o_next == CH_FIRST) ||
                       (o_ch != CH_LAST && o_next == o_ch + 2'd1)))
    else $error("next_channel does not follow sampled_channel");

  // hottest is the round minimum, so never above this channel's average
  a_hot_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_hot <= o_avg))
    else $error("hottest_reading above averaged_reading");

  // unused codes never appear
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_ch != 2'd3 && o_alarm != 2'd3 && m_axis_tdata[23:22] == 2'b00))
    else $error("illegal code in result");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed under back-pressure");

endmodule

bind three_channel_thermal_monitor tmon_checker u_tmon_checker (.*);
